>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/asp_pkg.sv
`timescale 1ns / 1ps
package asp_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int QuatFrac  = 30;

  localparam int CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] CfgMode      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMagnitude = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgAxisX     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgAxisY     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgAxisZ     = 3'd4;

  localparam logic [1:0] ModeDipole   = 2'd0;
  localparam logic [1:0] ModeVelocity = 2'd1;
  localparam logic [1:0] ModeQuat     = 2'd2;

  // Pipeline depths of the units.
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  localparam int UvLat     = 3 + 1 + SqrtSteps + DivSteps + 1;
  localparam int RotLat    = 4;
  localparam int ScaleLat  = 3;
  localparam int TotalLat  = 1 + UvLat + ScaleLat;

  typedef logic signed [DataWidth-1:0] word_t;
  typedef word_t [2:0] vec3_t;

  typedef struct packed {
    logic  in_group;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
    word_t quat_w;
    word_t quat_i;
    word_t quat_j;
    word_t quat_k;
    word_t force_x;
    word_t force_y;
    word_t force_z;
    logic  last_atom;
  } asp_in_t;

  typedef struct packed {
    word_t new_force_x;
    word_t new_force_y;
    word_t new_force_z;
    word_t push_x;
    word_t push_y;
    word_t push_z;
    logic  last_out;
  } asp_out_t;

  typedef struct packed {
    logic [1:0] mode;
    word_t      magnitude;
    vec3_t      axis;
  } asp_cfg_t;

  // Saturates a wide signed value to the signed data width.
  function automatic word_t sat_word(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    word_t r;
    hi = (64'sd1 <<< (DataWidth - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      r = hi[DataWidth-1:0];
    end else if (x < lo) begin
      r = lo[DataWidth-1:0];
    end else begin
      r = x[DataWidth-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/asp_unit_vec.sv
`timescale 1ns / 1ps
module asp_unit_vec (
  input  logic          clk_i,
  input  asp_pkg::vec3_t vec_i,
  output asp_pkg::vec3_t dir_o
);
  import asp_pkg::*;

  // Stage A: magnitudes and the largest one.
  logic [2:0][31:0] ma_q;
  logic [2:0]       nega_q;
  logic [31:0]      biga_q;
  // Stage B: normalized magnitudes.
  logic [2:0][31:0] mb_q;
  logic [2:0]       negb_q;
  logic             zerob_q;
  // Stage C: squares.
  logic [2:0][63:0] sqc_q;
  logic [2:0][31:0] mc_q;
  logic [2:0]       negc_q;
  logic             zeroc_q;
  // Square root stages; index 0 holds the sum of squares.
  logic [63:0]      sq_n_q    [SqrtSteps+1];
  logic [63:0]      sq_res_q  [SqrtSteps+1];
  logic [2:0][31:0] sq_m_q    [SqrtSteps+1];
  logic [2:0]       sq_neg_q  [SqrtSteps+1];
  logic             sq_zero_q [SqrtSteps+1];
  logic [63:0]      sq_n_d    [SqrtSteps];
  logic [63:0]      sq_res_d  [SqrtSteps];
  // Divider stages, one quotient bit each.
  logic [2:0][31:0] dv_r_q    [DivSteps];
  logic [2:0][30:0] dv_qt_q   [DivSteps];
  logic [31:0]      dv_den_q  [DivSteps];
  logic [2:0]       dv_neg_q  [DivSteps];
  logic             dv_zero_q [DivSteps];
  logic [2:0][31:0] dv_r_d    [DivSteps];
  logic [2:0][30:0] dv_qt_d   [DivSteps];
  logic [2:0][31:0] dv_rin    [DivSteps];
  logic [2:0][30:0] dv_qin    [DivSteps];
  logic [2:0]       dv_nb     [DivSteps];
  logic [31:0]      dv_denin  [DivSteps];
  logic [2:0]       dv_negin  [DivSteps];
  logic             dv_zeroin [DivSteps];
  vec3_t            dir_q;

  logic [2:0][31:0] ma_d;
  logic [31:0]      biga_d;
  logic [4:0]       pos;
  logic [4:0]       shamt;

  always_comb begin
    biga_d = '0;
    for (int c = 0; c < 3; c++) begin
      ma_d[c] = vec_i[c][31] ? 32'(-vec_i[c]) : 32'(vec_i[c]);
      if (ma_d[c] > biga_d) begin
        biga_d = ma_d[c];
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (biga_q[i]) begin
        pos = 5'(i);
      end
    end
    shamt = (pos >= 5'd30) ? 5'd0 : 5'(5'd30 - pos);
  end

  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    for (int t = 0; t < SqrtSteps; t++) begin
      bitv  = 64'd1 << (62 - 2 * t);
      trial = sq_res_q[t] + bitv;
      if (sq_n_q[t] >= trial) begin
        sq_n_d[t]   = sq_n_q[t] - trial;
        sq_res_d[t] = (sq_res_q[t] >> 1) + bitv;
      end else begin
        sq_n_d[t]   = sq_n_q[t];
        sq_res_d[t] = sq_res_q[t] >> 1;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dv_rin[0][c] = {1'b0, sq_m_q[SqrtSteps][c][31:1]};
      dv_nb[0][c]  = sq_m_q[SqrtSteps][c][0];
      dv_qin[0][c] = '0;
    end
    dv_denin[0]  = sq_res_q[SqrtSteps][31:0];
    dv_negin[0]  = sq_neg_q[SqrtSteps];
    dv_zeroin[0] = sq_zero_q[SqrtSteps];
    for (int k = 1; k < DivSteps; k++) begin
      dv_rin[k]    = dv_r_q[k-1];
      dv_qin[k]    = dv_qt_q[k-1];
      dv_nb[k]     = '0;
      dv_denin[k]  = dv_den_q[k-1];
      dv_negin[k]  = dv_neg_q[k-1];
      dv_zeroin[k] = dv_zero_q[k-1];
    end
  end

  always_comb begin
    logic [32:0] rs;
    for (int k = 0; k < DivSteps; k++) begin
      for (int c = 0; c < 3; c++) begin
        rs = {dv_rin[k][c], dv_nb[k][c]};
        if (rs >= {1'b0, dv_denin[k]}) begin
          dv_r_d[k][c]  = 32'(rs - {1'b0, dv_denin[k]});
          dv_qt_d[k][c] = {dv_qin[k][c][29:0], 1'b1};
        end else begin
          dv_r_d[k][c]  = rs[31:0];
          dv_qt_d[k][c] = {dv_qin[k][c][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    biga_q <= biga_d;
    for (int c = 0; c < 3; c++) begin
      nega_q[c] <= vec_i[c][31];
      mb_q[c]   <= ma_q[c] << shamt;
      mc_q[c]   <= mb_q[c];
      sqc_q[c]  <= 64'(mb_q[c]) * 64'(mb_q[c]);
    end
    negb_q  <= nega_q;
    zerob_q <= (biga_q == '0);
    negc_q  <= negb_q;
    zeroc_q <= zerob_q;

    sq_n_q[0]    <= sqc_q[0] + sqc_q[1] + sqc_q[2];
    sq_res_q[0]  <= '0;
    sq_m_q[0]    <= mc_q;
    sq_neg_q[0]  <= negc_q;
    sq_zero_q[0] <= zeroc_q;
    for (int t = 0; t < SqrtSteps; t++) begin
      sq_n_q[t+1]    <= sq_n_d[t];
      sq_res_q[t+1]  <= sq_res_d[t];
      sq_m_q[t+1]    <= sq_m_q[t];
      sq_neg_q[t+1]  <= sq_neg_q[t];
      sq_zero_q[t+1] <= sq_zero_q[t];
    end

    for (int k = 0; k < DivSteps; k++) begin
      dv_r_q[k]    <= dv_r_d[k];
      dv_qt_q[k]   <= dv_qt_d[k];
      dv_den_q[k]  <= dv_denin[k];
      dv_neg_q[k]  <= dv_negin[k];
      dv_zero_q[k] <= dv_zeroin[k];
    end

    for (int c = 0; c < 3; c++) begin
      if (dv_zero_q[DivSteps-1]) begin
        dir_q[c] <= '0;
      end else if (dv_neg_q[DivSteps-1][c]) begin
        dir_q[c] <= -$signed({1'b0, dv_qt_q[DivSteps-1][c]});
      end else begin
        dir_q[c] <= $signed({1'b0, dv_qt_q[DivSteps-1][c]});
      end
    end
  end

  assign dir_o = dir_q;

endmodule

>>> hw/rtl/asp_rotate.sv
`timescale 1ns / 1ps
module asp_rotate (
  input  logic            clk_i,
  input  asp_pkg::word_t  quat_w_i,
  input  asp_pkg::word_t  quat_i_i,
  input  asp_pkg::word_t  quat_j_i,
  input  asp_pkg::word_t  quat_k_i,
  input  asp_pkg::vec3_t  axis_i,
  output asp_pkg::vec3_t  rot_o
);
  import asp_pkg::*;

  // Products: ww ii jj kk ij ik jk wi wj wk.
  logic signed [63:0] p_q [10];
  word_t              ent_q [3][3];
  logic signed [63:0] pr_q [3][3];
  vec3_t              rot_q;

  logic signed [63:0] f [10];
  logic signed [63:0] e [3][3];
  logic signed [63:0] acc [3];

  always_comb begin
    for (int n = 0; n < 10; n++) begin
      f[n] = p_q[n] >>> QuatFrac;
    end
    e[0][0] = f[0] + f[1] - f[2] - f[3];
    e[0][1] = (f[4] - f[9]) <<< 1;
    e[0][2] = (f[5] + f[8]) <<< 1;
    e[1][0] = (f[4] + f[9]) <<< 1;
    e[1][1] = f[0] - f[1] + f[2] - f[3];
    e[1][2] = (f[6] - f[7]) <<< 1;
    e[2][0] = (f[5] - f[8]) <<< 1;
    e[2][1] = (f[6] + f[7]) <<< 1;
    e[2][2] = f[0] - f[1] - f[2] + f[3];
    for (int r = 0; r < 3; r++) begin
      acc[r] = (pr_q[r][0] >>> QuatFrac) + (pr_q[r][1] >>> QuatFrac)
             + (pr_q[r][2] >>> QuatFrac);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= 64'(quat_w_i) * 64'(quat_w_i);
    p_q[1] <= 64'(quat_i_i) * 64'(quat_i_i);
    p_q[2] <= 64'(quat_j_i) * 64'(quat_j_i);
    p_q[3] <= 64'(quat_k_i) * 64'(quat_k_i);
    p_q[4] <= 64'(quat_i_i) * 64'(quat_j_i);
    p_q[5] <= 64'(quat_i_i) * 64'(quat_k_i);
    p_q[6] <= 64'(quat_j_i) * 64'(quat_k_i);
    p_q[7] <= 64'(quat_w_i) * 64'(quat_i_i);
    p_q[8] <= 64'(quat_w_i) * 64'(quat_j_i);
    p_q[9] <= 64'(quat_w_i) * 64'(quat_k_i);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ent_q[r][c] <= sat_word(e[r][c]);
        pr_q[r][c]  <= 64'(ent_q[r][c]) * 64'($signed(axis_i[c]));
      end
      rot_q[r] <= sat_word(acc[r]);
    end
  end

  assign rot_o = rot_q;

endmodule

>>> hw/rtl/asp_scale.sv
`timescale 1ns / 1ps
module asp_scale (
  input  logic              clk_i,
  input  asp_pkg::asp_cfg_t cfg_i,
  input  logic              in_group_i,
  input  logic              last_i,
  input  asp_pkg::vec3_t    vec_i,
  input  asp_pkg::vec3_t    unit_i,
  input  asp_pkg::vec3_t    rot_i,
  input  asp_pkg::vec3_t    force_i,
  output asp_pkg::asp_out_t out_o
);
  import asp_pkg::*;

  logic signed [63:0] prod_q [3];
  logic               apply_q;
  logic               dip_q;
  vec3_t              force_q;
  logic               last_q;
  vec3_t              push_q;
  vec3_t              force2_q;
  logic               last2_q;
  asp_out_t           out_q;

  vec3_t              op;
  logic               apply;
  logic signed [63:0] sh [3];
  vec3_t              newf;

  always_comb begin
    unique case (cfg_i.mode)
      ModeDipole:   op = vec_i;
      ModeVelocity: op = unit_i;
      default:      op = rot_i;
    endcase
    apply = in_group_i && (cfg_i.mode == ModeDipole || cfg_i.mode == ModeVelocity
                           || cfg_i.mode == ModeQuat);
    for (int c = 0; c < 3; c++) begin
      sh[c]   = dip_q ? (prod_q[c] >>> FracBits) : (prod_q[c] >>> QuatFrac);
      newf[c] = sat_word(64'($signed(force2_q[c])) + 64'($signed(push_q[c])));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= 64'($signed(cfg_i.magnitude)) * 64'($signed(op[c]));
      push_q[c] <= apply_q ? sat_word(sh[c]) : '0;
    end
    apply_q  <= apply;
    dip_q    <= (cfg_i.mode == ModeDipole);
    force_q  <= force_i;
    last_q   <= last_i;
    force2_q <= force_q;
    last2_q  <= last_q;
    out_q.new_force_x <= newf[0];
    out_q.new_force_y <= newf[1];
    out_q.new_force_z <= newf[2];
    out_q.push_x      <= push_q[0];
    out_q.push_y      <= push_q[1];
    out_q.push_z      <= push_q[2];
    out_q.last_out    <= last2_q;
  end

  assign out_o = out_q;

endmodule

>>> hw/rtl/active_self_propulsion_force.sv
`timescale 1ns / 1ps
// Self-propulsion force stage for a particle stream.
// Items enter on in_item_i when start_i is high; busy_o stays low, so one item
// can be taken in every clock cycle. Each item gives exactly one result on
// out_item_o, marked by done_o for a single cycle. The receiver cannot hold
// results off, and none is needed: nothing in the pipeline ever waits.
// The delay from input to result is the same for every mode; throughput is
// one item per cycle. The pipeline depth is set by the velocity path: a
// 32-stage square root and a 31-stage divider, each stage resolving one
// result bit, plus normalization, squaring, input and output registers.
// The dipole and quaternion paths are delayed to match.
// Configuration goes through cfg_we_i, cfg_idx_i and cfg_data_i, one register
// per write. The user must change it only while no item is in flight; the
// block does not enforce this. Reset clears the valid pipeline, so no result
// appears for items that were in flight, and returns the registers to dipole
// mode, zero magnitude and a body axis along x.
module active_self_propulsion_force (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  asp_pkg::asp_in_t                    in_item_i,
  output logic                                done_o,
  output asp_pkg::asp_out_t                   out_item_o,
  input  logic                                cfg_we_i,
  input  logic [asp_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [asp_pkg::DataWidth-1:0]       cfg_data_i
);
  import asp_pkg::*;

  localparam int RotDly = UvLat - RotLat;

  // Fields that ride alongside the long velocity path.
  typedef struct packed {
    logic  in_group;
    logic  last_atom;
    vec3_t vec;
    vec3_t frc;
  } side_t;

  asp_cfg_t cfg_q;
  asp_in_t  in_q;
  logic     vld_q [TotalLat];
  side_t    sd_q  [UvLat];
  vec3_t    rd_q  [RotDly];

  vec3_t    in_vec;
  vec3_t    in_force;
  vec3_t    unit_dir;
  vec3_t    rot_dir;

  // The pipeline never stalls, so an item is taken in every cycle.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= ModeDipole;
      cfg_q.magnitude <= '0;
      cfg_q.axis[0]   <= word_t'(64'sd1 <<< QuatFrac);
      cfg_q.axis[1]   <= '0;
      cfg_q.axis[2]   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMode:      cfg_q.mode      <= cfg_data_i[1:0];
        CfgMagnitude: cfg_q.magnitude <= cfg_data_i;
        CfgAxisX:     cfg_q.axis[0]   <= cfg_data_i;
        CfgAxisY:     cfg_q.axis[1]   <= cfg_data_i;
        CfgAxisZ:     cfg_q.axis[2]   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The valid bit travels with the item through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TotalLat; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int s = 1; s < TotalLat; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign in_vec   = {in_q.vec_z, in_q.vec_y, in_q.vec_x};
  assign in_force = {in_q.force_z, in_q.force_y, in_q.force_x};

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_q <= in_item_i;
    sd_q[0].in_group  <= in_q.in_group;
    sd_q[0].last_atom <= in_q.last_atom;
    sd_q[0].vec       <= in_vec;
    sd_q[0].frc       <= in_force;
    for (int s = 1; s < UvLat; s++) begin
      sd_q[s] <= sd_q[s-1];
    end
    rd_q[0] <= rot_dir;
    for (int s = 1; s < RotDly; s++) begin
      rd_q[s] <= rd_q[s-1];
    end
  end

  asp_unit_vec u_unit_vec (
    .clk_i (clk_i),
    .vec_i (in_vec),
    .dir_o (unit_dir)
  );

  asp_rotate u_rotate (
    .clk_i    (clk_i),
    .quat_w_i (in_q.quat_w),
    .quat_i_i (in_q.quat_i),
    .quat_j_i (in_q.quat_j),
    .quat_k_i (in_q.quat_k),
    .axis_i   (cfg_q.axis),
    .rot_o    (rot_dir)
  );

  asp_scale u_scale (
    .clk_i      (clk_i),
    .cfg_i      (cfg_q),
    .in_group_i (sd_q[UvLat-1].in_group),
    .last_i     (sd_q[UvLat-1].last_atom),
    .vec_i      (sd_q[UvLat-1].vec),
    .unit_i     (unit_dir),
    .rot_i      (rd_q[RotDly-1]),
    .force_i    (sd_q[UvLat-1].frc),
    .out_o      (out_item_o)
  );

  assign done_o = vld_q[TotalLat-1];

endmodule

>>> hw/rtl/asp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module asp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input asp_pkg::asp_in_t  in_item_i,
  input logic              done_o,
  input asp_pkg::asp_out_t out_item_o
);
  import asp_pkg::*;

  localparam int CntWidth = $clog2(TotalLat + 1);

  // Cycles since reset, so history checks only look past reset.
  logic [CntWidth-1:0] cnt_q;
  logic                warm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != CntWidth'(TotalLat)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign warm = (cnt_q == CntWidth'(TotalLat));

  `ASP_ASSERT_IMP(a_one_result, warm, done_o == $past(start_i && !busy_o, TotalLat), "result count mismatch")
  `ASP_ASSERT_IMP(a_last_tag, warm && done_o, out_item_o.last_out == $past(in_item_i.last_atom, TotalLat), "last flag out of order")
  `ASP_ASSERT_IMP(a_pass_through, warm && done_o && !$past(in_item_i.in_group, TotalLat), out_item_o.push_x == '0 && out_item_o.new_force_x == $past(in_item_i.force_x, TotalLat), "outside item changed")
  `ASP_ASSERT_IMP(a_no_early, !warm && !$past(start_i && !busy_o), !done_o || cnt_q != '0, "result right after reset")

endmodule

bind active_self_propulsion_force asp_checker u_asp_checker (.*);
